>>> src/spr_pkg.sv
// Shared types and constants for the stream pattern replace block.
// No dependencies; compile first.
`default_nettype none

package spr_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_LEN_W  = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_last;
  } result_t;

endpackage

`default_nettype wire

>>> src/spr_if.sv
// Valid/ready channel interfaces for the input bytes and the result bytes.
// No dependencies.
`default_nettype none

interface spr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface spr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_last;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input text_last, output ready);
endinterface

`default_nettype wire

>>> src/stream_pattern_replace_unit.sv
// Streaming find-and-replace over a byte text. Each text item is appended to a hold buffer of
// up to PATTERN_MAX bytes; one shared compare unit then checks the held bytes against the
// pattern once per cycle, releasing one leading byte per cycle, as the output register allows,
// until the rest is a proper prefix again, or starting the replacement after a full match.
// The block takes one item at a time and is not ready while it works on a text byte, a
// match's replacement, or an end-of-text item and its held bytes. The one-result-per-cycle
// output register and its downstream ready can add stalls.
`default_nettype none

module stream_pattern_replace_unit #(
  parameter int PATTERN_MAX = spr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = spr_pkg::REPLACE_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data,
  spr_in_if.sink                               in_ch,
  spr_out_if.source                            out_ch
);
  import spr_pkg::*;

  localparam int CW  = $clog2(PATTERN_MAX + 1);
  localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RCW = $clog2(REPLACE_MAX + 1);
  localparam int RW  = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_REPL  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_bytes_r;
  logic [CFG_LEN_W-1:0]  pat_len_r;
  logic [CFG_DATA_W-1:0] rep_bytes_r;
  logic [CFG_LEN_W-1:0]  rep_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= CFG_LEN_W'(1);
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_BYTES: pat_bytes_r <= cfg_data;
        CFG_PAT_LEN:   pat_len_r   <= cfg_data[CFG_LEN_W-1:0];
        CFG_REP_BYTES: rep_bytes_r <= cfg_data;
        CFG_REP_LEN:   rep_len_r   <= cfg_data[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]  plen_eff;
  logic [RCW-1:0] rlen_eff;

  always_comb begin
    if (pat_len_r == '0) begin
      plen_eff = CW'(1);
    end else if (pat_len_r > CFG_LEN_W'(PATTERN_MAX)) begin
      plen_eff = CW'(PATTERN_MAX);
    end else begin
      plen_eff = CW'(pat_len_r);
    end
    if (rep_len_r > CFG_LEN_W'(REPLACE_MAX)) begin
      rlen_eff = RCW'(REPLACE_MAX);
    end else begin
      rlen_eff = RCW'(rep_len_r);
    end
  end

  // Sequencer state
  logic [1:0]     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           first_r, first_nxt;
  logic           pend_vld_r, pend_vld_nxt;
  logic [7:0]     pend_byte_r, pend_byte_nxt;
  logic [RCW-1:0] ridx_r, ridx_nxt;
  logic [7:0]     hold_r [PATTERN_MAX];

  logic    in_acc;
  logic    match;
  logic    load, shift;
  logic    push, out_free;
  result_t push_d;
  logic    rep_last;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rep_last    = (RCW'(ridx_r + 1'b1) == rlen_eff);

  spr_cmp #(.PATTERN_MAX(PATTERN_MAX)) u_cmp (
    .buf_i   (hold_r),
    .pat_i   (pat_bytes_r),
    .len_i   (cnt_r),
    .match_o (match)
  );

  spr_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_d (push_d),
    .free   (out_free),
    .out_ch (out_ch)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    ridx_nxt      = ridx_r;
    load          = 1'b0;
    shift         = 1'b0;
    push          = 1'b0;
    push_d        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind) begin
            state_nxt = ST_FLUSH;
          end else begin
            load      = 1'b1;
            cnt_nxt   = CW'(cnt_r + 1'b1);
            first_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (first_r && (cnt_r == plen_eff) && match) begin
          cnt_nxt   = '0;
          ridx_nxt  = '0;
          state_nxt = (rlen_eff == '0) ? ST_IDLE : ST_REPL;
        end else if ((cnt_r != '0) && ((cnt_r >= plen_eff) || !match)) begin
          // release the leading byte; the previous one goes out now that it is not last
          if (!pend_vld_r || out_free) begin
            push          = pend_vld_r;
            push_d        = '{out_byte: pend_byte_r, byte_valid: 1'b1,
                              run_last: 1'b0, text_last: 1'b0};
            pend_vld_nxt  = 1'b1;
            pend_byte_nxt = hold_r[0];
            shift         = 1'b1;
            cnt_nxt       = CW'(cnt_r - 1'b1);
            first_nxt     = 1'b0;
          end
        end else begin
          if (!pend_vld_r || out_free) begin
            push         = pend_vld_r;
            push_d       = '{out_byte: pend_byte_r, byte_valid: 1'b1,
                             run_last: 1'b1, text_last: 1'b0};
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_REPL: begin
        if (out_free) begin
          push     = 1'b1;
          push_d   = '{out_byte: rep_bytes_r[{ridx_r[RW-1:0], 3'b000} +: 8], byte_valid: 1'b1,
                       run_last: rep_last, text_last: 1'b0};
          ridx_nxt = RCW'(ridx_r + 1'b1);
          if (rep_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push = 1'b1;
          if (cnt_r == '0) begin
            // nothing held: bare end mark
            push_d    = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, text_last: 1'b1};
            state_nxt = ST_IDLE;
          end else begin
            push_d  = '{out_byte: hold_r[0], byte_valid: 1'b1,
                        run_last: (cnt_r == CW'(1)), text_last: (cnt_r == CW'(1))};
            shift   = 1'b1;
            cnt_nxt = CW'(cnt_r - 1'b1);
            if (cnt_r == CW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      first_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      ridx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      first_r    <= first_nxt;
      pend_vld_r <= pend_vld_nxt;
      ridx_r     <= ridx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
  end

  // Hold buffer: append at the fill point, advance by one byte on release
  always_ff @(posedge clk) begin
    if (load) begin
      hold_r[cnt_r[IW-1:0]] <= in_ch.in_byte;
    end else if (shift) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        hold_r[i] <= hold_r[i+1];
      end
    end
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r < CW'(PATTERN_MAX)))
    else $error("hold count reached the buffer depth while idle");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == ST_SCAN))
    else $error("pending byte outside a scan");

  a_repl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPL) |-> (cnt_r == '0))
    else $error("bytes held during replacement");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && (state_nxt == ST_IDLE)) |=> (cnt_r == '0))
    else $error("flush left bytes held");

endmodule

`default_nettype wire

>>> src/spr_cmp.sv
// Shared prefix compare unit: checks the first len_i held bytes against the pattern.
// Depends on spr_pkg.
`default_nettype none

module spr_cmp #(
  parameter int PATTERN_MAX = spr_pkg::PATTERN_MAX_DEF
) (
  input  wire logic [7:0]                       buf_i [PATTERN_MAX],
  input  wire logic [spr_pkg::CFG_DATA_W-1:0]   pat_i,
  input  wire logic [$clog2(PATTERN_MAX+1)-1:0] len_i,
  output logic                                  match_o
);
  import spr_pkg::*;

  localparam int CW = $clog2(PATTERN_MAX + 1);

  always_comb begin
    match_o = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((CW'(i) < len_i) && (buf_i[i] != pat_i[8*i +: 8])) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/spr_obuf.sv
// Output register for result items: parts the sequencer from the result channel.
// Depends on spr_pkg and spr_if.
`default_nettype none

module spr_obuf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire spr_pkg::result_t push_d,
  output logic                  free,
  spr_out_if.source             out_ch
);
  import spr_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      data_r <= push_d;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.out_byte   = data_r.out_byte;
  assign out_ch.byte_valid = data_r.byte_valid;
  assign out_ch.run_last   = data_r.run_last;
  assign out_ch.text_last  = data_r.text_last;

endmodule

`default_nettype wire
